// ----- hdl/ll1_table_driven_parser_assert.svh -----
// Assertion macros for the LL(1) table-driven parser.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef LL1_TABLE_DRIVEN_PARSER_ASSERT_SVH
`define LL1_TABLE_DRIVEN_PARSER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define LL1P_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LL1P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

// ----- hdl/ll1p_pkg.sv -----
// Package for the LL(1) table-driven parser: payload types, status and
// register codes, reset values and table lookup functions. No dependencies.
`default_nettype none

package ll1p_pkg;

  typedef struct packed {
    logic       action;
    logic [1:0] token;
  } ll1p_in_t;

  typedef struct packed {
    logic [3:0] status;
    logic [1:0] rule_index;
    logic [2:0] expanded_symbol;
    logic       last;
  } ll1p_out_t;

  localparam logic [3:0] ST_EXPAND   = 4'd0;
  localparam logic [3:0] ST_MATCH    = 4'd1;
  localparam logic [3:0] ST_ACCEPT   = 4'd2;
  localparam logic [3:0] ST_NOENTRY  = 4'd3;
  localparam logic [3:0] ST_MISMATCH = 4'd4;
  localparam logic [3:0] ST_TRAILING = 4'd5;
  localparam logic [3:0] ST_OVERFLOW = 4'd6;
  localparam logic [3:0] ST_LIMIT    = 4'd7;
  localparam logic [3:0] ST_RESTART  = 4'd8;
  localparam logic [3:0] ST_IGNORED  = 4'd9;

  localparam logic [1:0] CFG_PARSE_TABLE  = 2'd0;
  localparam logic [1:0] CFG_RULE_TABLE   = 2'd1;
  localparam logic [1:0] CFG_START_SYMBOL = 2'd2;

  localparam logic [26:0] PARSE_TABLE_RST  = 27'd125662151;
  localparam logic [43:0] RULE_TABLE_RST   = 44'd42951514226;
  localparam logic [2:0]  START_SYMBOL_RST = 3'd2;

  localparam logic [2:0] NO_ENTRY  = 3'd7;
  localparam logic [1:0] TOKEN_END = 2'd2;
  localparam logic [1:0] TOKEN_BAD = 2'd3;

  function automatic logic sym_is_nt(logic [2:0] sym);
    return (sym inside {[3'd2:3'd4]});
  endfunction

  function automatic logic [2:0] pt_entry(logic [26:0] table_bits, logic [2:0] sym,
                                          logic [1:0] tok);
    logic [2:0] nt;
    logic [3:0] col;
    nt  = sym - 3'd2;
    col = 4'(nt[1:0]) * 4'd3 + 4'(tok);
    if (tok == TOKEN_BAD || !sym_is_nt(sym)) begin
      return NO_ENTRY;
    end
    return table_bits[3*col +: 3];
  endfunction

  function automatic logic [10:0] rule_sel(logic [43:0] rules, logic [1:0] idx);
    return rules[11*idx +: 11];
  endfunction

  function automatic logic [2:0] rule_sym(logic [10:0] rule, logic [1:0] pos);
    logic [2:0] sym;
    case (pos)
      2'd1:    sym = rule[4:2];
      2'd2:    sym = rule[7:5];
      2'd3:    sym = rule[10:8];
      default: sym = 3'd0;
    endcase
    return sym;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ll1p_stack.sv -----
// Symbol stack memory of the LL(1) parser: one write port and one
// registered read port. Uses ll1p_pkg for the reset start symbol.
`default_nettype none

module ll1p_stack import ll1p_pkg::*; #(
  parameter int STACK_DEPTH = 32,
  parameter int AW          = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [2:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [2:0]    rdata_o
);

  logic [2:0] mem_q [STACK_DEPTH];
  logic [2:0] rd_q;
  logic       bottom_valid_q;
  logic       rd_bottom_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  // Entry zero holds the reset start symbol until it is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_valid_q <= 1'b0;
      rd_bottom_q    <= 1'b0;
    end else begin
      if (we_i && waddr_i == '0) begin
        bottom_valid_q <= 1'b1;
      end
      rd_bottom_q <= (raddr_i == '0) && !bottom_valid_q;
    end
  end

  assign rdata_o = rd_bottom_q ? START_SYMBOL_RST : rd_q;

endmodule

`default_nettype wire

// ----- hdl/ll1_table_driven_parser.sv -----
// Usage: LL(1) table-driven recognizer with an input request channel
// (in_valid_i, in_stall_o, in_data_i), a result channel (out_valid_o,
// out_stall_i, out_data_o) and a register write port (cfg_valid_i,
// cfg_ready_o, cfg_index_i, cfg_data_i) that is always ready.
// A request is either a restart or one token. It is taken only while the
// sequencer is idle, then yields one result per expansion and one final
// result marked by last.
// Every result is loaded into the output register at the end of its
// evaluation cycle, so a restart, an ignored token, a match, a final error or
// accept goes from the request register through S_EVAL to the output register.
// Each expansion is evaluated in S_EVAL, then its rule symbols are pushed in
// S_PUSH, last first; an empty rule reloads the top of stack via S_READ and
// S_LOAD unless the stack is left empty. After a match that leaves symbols on
// the stack, S_READ and S_LOAD reload the top before the next request is taken.
// Reset loads the register reset values and a stack holding only the start
// symbol. While the receiver stalls, the result is held and the sequencer
// waits before producing the next result.
// Depends on ll1p_pkg, ll1p_stack and ll1_table_driven_parser_assert.svh.
`default_nettype none

`include "ll1_table_driven_parser_assert.svh"

module ll1_table_driven_parser import ll1p_pkg::*; #(
  parameter int STACK_DEPTH    = 32,
  parameter int MAX_EXPANSIONS = 15,
  parameter int NUM_RULES      = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ll1p_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output ll1p_out_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [43:0] cfg_data_i
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = $clog2(MAX_EXPANSIONS + 1);
  localparam logic [2:0]    NumRulesC = 3'(NUM_RULES);
  localparam logic [EW-1:0] MaxExpC   = EW'(MAX_EXPANSIONS);
  localparam logic [DW:0]   DepthC    = (DW+1)'(STACK_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_PUSH = 5'b00100,
    S_READ = 5'b01000,
    S_LOAD = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [26:0]    parse_table_q;
  logic [43:0]    rule_table_q;
  logic [2:0]     start_symbol_q;
  ll1p_in_t       req_q, req_d;
  logic [DW-1:0]  depth_q, depth_d;
  logic [2:0]     top_q, top_d;
  logic           finished_q, finished_d;
  logic [EW-1:0]  exp_cnt_q, exp_cnt_d;
  logic [10:0]    rule_q, rule_d;
  logic [1:0]     push_cnt_q, push_cnt_d;
  logic           ret_eval_q, ret_eval_d;
  logic           out_valid_q, out_valid_d;
  ll1p_out_t      out_q, out_d;

  logic           out_free;
  logic [2:0]     entry;
  logic [10:0]    rule_sel_w;
  logic [DW:0]    ovf_sum;
  logic [DW-1:0]  depth_m1;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [2:0]     wdata;
  logic [2:0]     rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_table_q  <= PARSE_TABLE_RST;
      rule_table_q   <= RULE_TABLE_RST;
      start_symbol_q <= START_SYMBOL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PARSE_TABLE:  parse_table_q  <= cfg_data_i[26:0];
        CFG_RULE_TABLE:   rule_table_q   <= cfg_data_i;
        CFG_START_SYMBOL: start_symbol_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign depth_m1   = depth_q - DW'(1);
  assign entry      = pt_entry(parse_table_q, top_q, req_q.token);
  assign rule_sel_w = rule_sel(rule_table_q, entry[1:0]);
  assign ovf_sum    = (DW+1)'(depth_m1) + (DW+1)'(rule_sel_w[1:0]);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    depth_d     = depth_q;
    top_d       = top_q;
    finished_d  = finished_q;
    exp_cnt_d   = exp_cnt_q;
    rule_d      = rule_q;
    push_cnt_d  = push_cnt_q;
    ret_eval_d  = ret_eval_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = depth_q[AW-1:0];
    wdata       = start_symbol_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_data_i;
          exp_cnt_d = '0;
          state_d   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: ST_IGNORED, rule_index: 2'd0,
                          expanded_symbol: 3'd0, last: 1'b1};
          state_d     = S_IDLE;
          if (req_q.action) begin
            out_d.status = ST_RESTART;
            we           = 1'b1;
            waddr        = '0;
            depth_d      = DW'(1);
            top_d        = start_symbol_q;
            finished_d   = 1'b0;
          end else if (finished_q) begin
            out_d.status = ST_IGNORED;
          end else if (depth_q == '0) begin
            finished_d   = 1'b1;
            out_d.status = (req_q.token == TOKEN_END) ? ST_ACCEPT : ST_TRAILING;
          end else if (!sym_is_nt(top_q)) begin
            if (top_q == {1'b0, req_q.token}) begin
              out_d.status = ST_MATCH;
              depth_d      = depth_m1;
              if (depth_m1 != '0) begin
                ret_eval_d = 1'b0;
                state_d    = S_READ;
              end
            end else begin
              finished_d   = 1'b1;
              out_d.status = ST_MISMATCH;
            end
          end else if (entry == NO_ENTRY || entry >= NumRulesC) begin
            finished_d   = 1'b1;
            out_d.status = ST_NOENTRY;
          end else if (exp_cnt_q >= MaxExpC) begin
            finished_d   = 1'b1;
            out_d.status = ST_LIMIT;
          end else if (ovf_sum > DepthC) begin
            finished_d   = 1'b1;
            out_d.status = ST_OVERFLOW;
          end else begin
            out_d      = '{status: ST_EXPAND, rule_index: entry[1:0],
                           expanded_symbol: top_q, last: 1'b0};
            exp_cnt_d  = exp_cnt_q + EW'(1);
            depth_d    = depth_m1;
            rule_d     = rule_sel_w;
            push_cnt_d = rule_sel_w[1:0];
            ret_eval_d = 1'b1;
            if (rule_sel_w[1:0] != 2'd0) begin
              state_d = S_PUSH;
            end else if (depth_m1 != '0) begin
              state_d = S_READ;
            end else begin
              state_d = S_EVAL;
            end
          end
        end
      end
      S_PUSH: begin
        we         = 1'b1;
        wdata      = rule_sym(rule_q, push_cnt_q);
        top_d      = wdata;
        depth_d    = depth_q + DW'(1);
        push_cnt_d = push_cnt_q - 2'd1;
        if (push_cnt_q == 2'd1) begin
          state_d = S_EVAL;
        end
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        top_d   = rdata;
        state_d = ret_eval_q ? S_EVAL : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= DW'(1);
      top_q       <= START_SYMBOL_RST;
      finished_q  <= 1'b0;
      exp_cnt_q   <= '0;
      push_cnt_q  <= '0;
      ret_eval_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      top_q       <= top_d;
      finished_q  <= finished_d;
      exp_cnt_q   <= exp_cnt_d;
      push_cnt_q  <= push_cnt_d;
      ret_eval_q  <= ret_eval_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rule_q <= rule_d;
    out_q  <= out_d;
  end

  ll1p_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(depth_m1[AW-1:0]),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LL1P_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DW'(STACK_DEPTH))
  `LL1P_ASSERT_IMP(a_exp_bound, 1'b1, exp_cnt_q <= MaxExpC)
  `LL1P_ASSERT_IMP(a_push_nonzero, state_q == S_PUSH, push_cnt_q != 2'd0)
  `LL1P_ASSERT_NEXT(a_take_eval, in_valid_i && !in_stall_o, state_q == S_EVAL)

endmodule

`default_nettype wire

// ----- dv/tb_ll1_table_driven_parser.sv -----
// Self-checking testbench for ll1_table_driven_parser: directed grammars and random tables,
// with a request-level parser model checking every result in order.
// Depends on ll1p_pkg and the ll1_table_driven_parser RTL.
`default_nettype none

module tb_ll1_table_driven_parser;
  import ll1p_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STK_DEPTH = 32;
  localparam int MAX_EXP   = 15;
  localparam int N_RULES   = 4;
  localparam int LIMIT     = 800000;

  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  ll1p_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  ll1p_out_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [43:0] cfg_data_i;

  logic [2:0]  sym_stack [STK_DEPTH];
  int          depth;
  bit          done;
  logic [26:0] pt_reg;
  logic [43:0] rt_reg;
  logic [2:0]  start_reg;

  ll1p_out_t   parse_results [$];
  int          errors;
  bit          burst;

  ll1_table_driven_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Runs one request through the parser state; with commit set it also queues the results.
  function automatic logic [3:0] step_parser(input ll1p_in_t req, input bit commit);
    logic [2:0]  s [STK_DEPTH];
    int          d;
    bit          fin;
    int          nexp;
    int          pos;
    int          len;
    logic [2:0]  top;
    logic [2:0]  entry;
    logic [10:0] rule;
    logic [3:0]  st;
    ll1p_out_t   res;
    s    = sym_stack;
    d    = depth;
    fin  = done;
    nexp = 0;
    if (req.action) begin
      for (int i = 0; i < STK_DEPTH; i++) s[i] = 3'd0;
      s[0] = start_reg;
      d    = 1;
      fin  = 1'b0;
      st   = ST_RESTART;
    end else if (fin) begin
      st = ST_IGNORED;
    end else begin
      st = ST_EXPAND;
      while (st == ST_EXPAND) begin
        if (d == 0) begin
          fin = 1'b1;
          st  = (req.token == TOKEN_END) ? ST_ACCEPT : ST_TRAILING;
        end else begin
          top = s[d-1];
          if (top < 3'd2 || top > 3'd4) begin
            if (top == {1'b0, req.token}) begin
              d--;
              st = ST_MATCH;
            end else begin
              fin = 1'b1;
              st  = ST_MISMATCH;
            end
          end else begin
            entry = NO_ENTRY;
            if (req.token != TOKEN_BAD) begin
              pos   = 3 * (3 * (int'(top) - 2) + int'(req.token));
              entry = pt_reg[pos +: 3];
            end
            if (int'(entry) >= N_RULES) begin
              fin = 1'b1;
              st  = ST_NOENTRY;
            end else if (nexp >= MAX_EXP) begin
              fin = 1'b1;
              st  = ST_LIMIT;
            end else begin
              rule = rt_reg[11*int'(entry) +: 11];
              len  = int'(rule[1:0]);
              if (d - 1 + len > STK_DEPTH) begin
                fin = 1'b1;
                st  = ST_OVERFLOW;
              end else begin
                if (commit) begin
                  res.status          = ST_EXPAND;
                  res.rule_index      = entry[1:0];
                  res.expanded_symbol = top;
                  res.last            = 1'b0;
                  parse_results.push_back(res);
                end
                nexp++;
                d--;
                for (int i = len; i > 0; i--) begin
                  s[d] = rule[2+3*(i-1) +: 3];
                  d++;
                end
              end
            end
          end
        end
      end
    end
    if (commit) begin
      res.status          = st;
      res.rule_index      = 2'd0;
      res.expanded_symbol = 3'd0;
      res.last            = 1'b1;
      parse_results.push_back(res);
      sym_stack = s;
      depth     = d;
      done      = fin;
    end
    return st;
  endfunction

  // Picks a token that keeps the current parse alive, if one exists.
  function automatic logic [1:0] pick_token();
    logic [1:0] ok [$];
    logic [3:0] st;
    ll1p_in_t   req;
    req.action = 1'b0;
    for (int t = 0; t < 3; t++) begin
      req.token = 2'(t);
      st = step_parser(req, 1'b0);
      if (st == ST_MATCH || st == ST_ACCEPT) ok.push_back(2'(t));
    end
    if (ok.size() == 0) return 2'($urandom_range(0, 3));
    return ok[$urandom_range(0, ok.size() - 1)];
  endfunction

  function automatic logic [26:0] pt_cell(logic [26:0] t, int sym, int col, logic [2:0] v);
    t[3*(3*(sym-2)+col) +: 3] = v;
    return t;
  endfunction

  function automatic logic [10:0] rule_bits(int len, int a, int b, int c);
    return {3'(c), 3'(b), 3'(a), 2'(len)};
  endfunction

  task automatic send_req(input logic action, input logic [1:0] tok);
    int       gap;
    ll1p_in_t req;
    req.action = action;
    req.token  = tok;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    void'(step_parser(req, 1'b1));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (parse_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [43:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PARSE_TABLE:  pt_reg    = data[26:0];
      CFG_RULE_TABLE:   rt_reg    = data;
      CFG_START_SYMBOL: start_reg = data[2:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_sentences(input int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 5) == 0);
      send_req(1'b1, 2'd0);
      sent++;
      len = 0;
      while (!done && len < 40 && sent < n_items) begin
        r = $urandom_range(0, 99);
        if (r == 99) send_req(1'b1, 2'($urandom_range(0, 3)));
        else if (r < 85) send_req(1'b0, pick_token());
        else send_req(1'b0, 2'($urandom_range(0, 3)));
        sent++;
        len++;
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          if (!done) sent++;
          send_req(1'b0, 2'($urandom_range(0, 3)));
        end
      end
    end
    burst = 1'b0;
  endtask

  function automatic logic [2:0] rand_sym();
    return ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
  endfunction

  task automatic load_random_tables();
    logic [26:0] pt;
    logic [43:0] rt;
    logic [2:0]  st;
    for (int c = 0; c < 9; c++) begin
      pt[3*c +: 3] = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 3))
                                                : 3'($urandom_range(4, 7));
    end
    for (int r = 0; r < 4; r++) begin
      rt[11*r +: 11] = rule_bits($urandom_range(0, 3), rand_sym(), rand_sym(), rand_sym());
    end
    st = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4));
    write_reg(CFG_PARSE_TABLE, {17'($urandom), pt});
    write_reg(CFG_RULE_TABLE, rt);
    write_reg(CFG_START_SYMBOL, {41'({$urandom, $urandom}), st});
  endtask

  task automatic test_reset_state();
    send_req(1'b0, pick_token());
    send_req(1'b0, TOKEN_BAD);
    send_req(1'b1, 2'd0);
    send_req(1'b0, pick_token());
    drain_results();
  endtask

  task automatic test_balanced();
    logic [26:0] pt;
    pt = '1;
    pt = pt_cell(pt, 2, 0, 3'd0);
    pt = pt_cell(pt, 2, 1, 3'd1);
    pt = pt_cell(pt, 2, 2, 3'd1);
    write_reg(CFG_PARSE_TABLE, {17'd0, pt});
    write_reg(CFG_RULE_TABLE, {22'd0, rule_bits(0, 0, 0, 0), rule_bits(3, 0, 2, 1)});
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd0);
    send_req(1'b0, 2'd0);
    send_req(1'b0, 2'd1);
    send_req(1'b0, 2'd1);
    send_req(1'b0, TOKEN_END);
    send_req(1'b0, 2'd1);
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd1);
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd0);
    send_req(1'b0, TOKEN_END);
    send_req(1'b1, 2'd0);
    send_req(1'b0, TOKEN_BAD);
    drain_results();
  endtask

  task automatic test_deep_stack();
    logic [26:0] pt;
    pt = '1;
    pt = pt_cell(pt, 2, 0, 3'd0);
    pt = pt_cell(pt, 3, 0, 3'd1);
    pt = pt_cell(pt, 4, 0, 3'd2);
    pt = pt_cell(pt, 2, 1, 3'd3);
    pt = pt_cell(pt, 2, 2, 3'd5);
    write_reg(CFG_PARSE_TABLE, {17'd0, pt});
    write_reg(CFG_RULE_TABLE, {rule_bits(1, 2, 0, 0), rule_bits(3, 0, 2, 2),
                               rule_bits(3, 4, 2, 2), rule_bits(3, 3, 2, 2)});
    send_req(1'b1, 2'd0);
    repeat (7) send_req(1'b0, 2'd0);
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd1);
    send_req(1'b1, 2'd0);
    send_req(1'b0, TOKEN_END);
    drain_results();
  endtask

  task automatic test_extreme_regs();
    write_reg(CFG_START_SYMBOL, 44'd0);
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd0);
    send_req(1'b0, TOKEN_END);
    drain_results();
    write_reg(CFG_START_SYMBOL, '1);
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd0);
    drain_results();
    write_reg(CFG_PARSE_TABLE, 44'd0);
    write_reg(CFG_RULE_TABLE, 44'd0);
    write_reg(CFG_START_SYMBOL, 44'd4);
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd1);
    drain_results();
    write_reg(CFG_RULE_TABLE, '1);
    send_req(1'b1, 2'd0);
    send_req(1'b0, 2'd0);
    drain_results();
    write_reg(CFG_PARSE_TABLE, '1);
    write_reg(CFG_UNMAPPED, '1);
    send_req(1'b1, 2'd0);
    send_req(1'b0, TOKEN_END);
    drain_results();
  endtask

  task automatic test_balanced_tables();
    logic [26:0] pt;
    pt = '1;
    pt = pt_cell(pt, 2, 0, 3'd0);
    pt = pt_cell(pt, 2, 1, 3'd1);
    pt = pt_cell(pt, 2, 2, 3'd1);
    write_reg(CFG_PARSE_TABLE, {17'd0, pt});
    write_reg(CFG_RULE_TABLE, {22'd0, rule_bits(0, 0, 0, 0), rule_bits(3, 0, 2, 1)});
    write_reg(CFG_START_SYMBOL, 44'd2);
  endtask

  task automatic test_random();
    test_balanced_tables();
    run_sentences(80);
    drain_results();
    repeat (4) begin
      load_random_tables();
      run_sentences(80);
      drain_results();
    end
  endtask

  initial begin
    ll1p_out_t got;
    ll1p_out_t want;
    int        hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (parse_results.size() == 0) begin
          $display("%0t: result with none pending, got status %0d", $time, got.status);
          errors++;
        end else begin
          want = parse_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.rule_index !== want.rule_index) begin
            $display("%0t: rule_index expected %0d got %0d", $time, want.rule_index,
                     got.rule_index);
            errors++;
          end
          if (got.expanded_symbol !== want.expanded_symbol) begin
            $display("%0t: expanded_symbol expected %0d got %0d", $time,
                     want.expanded_symbol, got.expanded_symbol);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
            errors++;
          end
        end
        hold = burst ? 0 : $urandom_range(0, 8);
        out_stall_i <= (hold != 0);
      end else if (hold != 0) begin
        hold--;
        out_stall_i <= (hold != 0);
      end
    end
  end

  initial begin
    errors      = 0;
    burst       = 1'b0;
    pt_reg      = PARSE_TABLE_RST;
    rt_reg      = RULE_TABLE_RST;
    start_reg   = START_SYMBOL_RST;
    for (int i = 0; i < STK_DEPTH; i++) sym_stack[i] = 3'd0;
    sym_stack[0] = START_SYMBOL_RST;
    depth       = 1;
    done        = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_state();
    test_balanced();
    test_deep_stack();
    test_extreme_regs();
    test_random();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
